// File: hdl/rmf_pkg.sv
// rmf_pkg: shared constants, item types and address helpers for the RGB median filter.
// No dependencies; imported by rmf_cell, rmf_sorter and rgb_median_filter.
package rmf_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_WINDOW  = 7;
	localparam int STORE_DEPTH = MAX_WINDOW * MAX_WIDTH;
	localparam int AW          = $clog2(STORE_DEPTH);
	localparam int CELLS       = MAX_WINDOW * MAX_WINDOW;
	localparam int RW          = $clog2(CELLS);

	localparam logic [8:0] KEY_EMPTY = 9'd256;

	localparam logic [2:0] REG_FRAME_WIDTH   = 3'd0;
	localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_WINDOW_SIZE   = 3'd2;
	localparam logic [2:0] REG_FILTER_ENABLE = 3'd3;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	typedef struct packed {
		logic       command;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       frame_last;
	} out_item_t;

	typedef logic [8:0] key_t;
	typedef key_t [2:0] trio_t;

	typedef struct packed {
		logic clear;
		logic insert;
	} sort_ctl_t;

	function automatic logic [AW-1:0] addr_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
		logic [AW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (AW+1)'(STORE_DEPTH)) s = s - (AW+1)'(STORE_DEPTH);
		return s[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] addr_sub(input logic [AW-1:0] a, input logic [AW-1:0] b);
		logic [AW-1:0] d;
		if (a >= b) d = a - b;
		else d = a - b + AW'(STORE_DEPTH);
		return d;
	endfunction

endpackage

// File: hdl/rmf_cell.sv
// rmf_cell: one slot of the insertion sort chain, three channels side by side.
// Depends on rmf_pkg.
module rmf_cell import rmf_pkg::*; (
	input  logic      clk,
	input  sort_ctl_t ctl,
	input  logic      first,
	input  trio_t     x,
	input  trio_t     prev,
	output trio_t     val
);

	trio_t val_q;

	// keep own key if not above x; else take x or shift in the left neighbor
	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			if (ctl.clear) begin
				val_q[c] <= KEY_EMPTY;
			end else if (ctl.insert && val_q[c] > x[c]) begin
				val_q[c] <= (first || prev[c] <= x[c]) ? x[c] : prev[c];
			end
		end
	end

	assign val = val_q;

endmodule

// File: hdl/rmf_sorter.sv
// rmf_sorter: chain of rmf_cell slots keeping the window samples in ascending order.
// Depends on rmf_pkg and rmf_cell.
module rmf_sorter import rmf_pkg::*; (
	input  logic          clk,
	input  sort_ctl_t     ctl,
	input  trio_t         x,
	input  logic [RW-1:0] rank,
	output logic [23:0]   median
);

	trio_t vals [CELLS];

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		if (i == 0) begin : g_head
			rmf_cell u_cell (
				.clk   (clk),
				.ctl   (ctl),
				.first (1'b1),
				.x     (x),
				.prev  (vals[0]),
				.val   (vals[0])
			);
		end else begin : g_body
			rmf_cell u_cell (
				.clk   (clk),
				.ctl   (ctl),
				.first (1'b0),
				.x     (x),
				.prev  (vals[i-1]),
				.val   (vals[i])
			);
		end
	end

	trio_t sel;
	assign sel    = vals[rank];
	assign median = {sel[2][7:0], sel[1][7:0], sel[0][7:0]};

endmodule

// File: hdl/rgb_median_filter.sv
// rgb_median_filter: streaming per-channel 2-D median filter on RGB pixels, top level.
// Depends on rmf_pkg, rmf_sorter (which holds the rmf_cell chain).
//
//  channel | direction | handshake              | payload
//  in      | to block  | in_valid / in_stall    | in_data  (in_item_t)
//  out     | from block| out_valid / out_stall  | out_data (out_item_t)
//  cfg     | to block  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// An item that gives no result leaves the block idle. For one that gives a result
// (k = effective window side, n = k*k window samples) the window
// is fetched one pixel per cycle through the single read port of the line store,
// each sample going into the sort chain, then the rank n/2 slot is registered.
// Reset clears counters and config to defaults; the line store is not cleared
// (entries are always written before a frame reads them). in_stall is high
// while an item is in work or its result waits on out_stall.
module rgb_median_filter import rmf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [11:0] cfg_data
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_GATHER = 5'b00010,
		ST_WAIT   = 5'b00100,
		ST_CAPT   = 5'b01000,
		ST_OUT    = 5'b10000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [10:0] fw_q;
	logic [11:0] fh_q;
	logic [2:0]  ws_q;
	logic        fe_q;

	// effective geometry
	logic [10:0] w_eff;
	logic [11:0] h_eff;
	logic [2:0]  k_eff;
	logic [1:0]  half;
	logic [12:0] lag;
	logic [22:0] total;
	logic [RW-1:0] rank;

	always_comb begin
		if (fw_q == 11'd0) w_eff = 11'd1;
		else if (fw_q > 11'(MAX_WIDTH)) w_eff = 11'(MAX_WIDTH);
		else w_eff = fw_q;
		h_eff = (fh_q == 12'd0) ? 12'd1 : fh_q;
		if (fe_q && ws_q[0] && ws_q >= 3'd3 && 32'(ws_q) <= MAX_WINDOW) k_eff = ws_q;
		else k_eff = 3'd1;
	end

	assign half  = k_eff[2:1];
	assign lag   = 13'(half) * 13'(w_eff) + 13'(half);
	assign total = 23'(w_eff) * 23'(h_eff);

	always_comb begin
		case (k_eff)
			3'd3:    rank = RW'(4);
			3'd5:    rank = RW'(12);
			3'd7:    rank = RW'(24);
			default: rank = '0;
		endcase
	end

	// frame position counters
	logic [22:0]   in_cnt_q, out_cnt_q;
	logic [AW-1:0] wr_addr_q, out_addr_q;
	logic [9:0]    out_col_q;
	logic [11:0]   out_row_q;

	// accept decode
	logic in_acc, cfg_acc, cfg_known;
	logic in_done, pix_ok, pix_emit, drain_emit, emit, last_px;
	logic [23:0] out_next;

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign cfg_known = (cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT) ||
	                   (cfg_index == REG_WINDOW_SIZE) || (cfg_index == REG_FILTER_ENABLE);

	assign in_done    = (in_cnt_q == total);
	assign pix_ok     = in_acc && (in_data.command == CMD_PIXEL) && !in_done;
	assign pix_emit   = pix_ok && ({1'b0, out_cnt_q} + 24'(lag) <= {1'b0, in_cnt_q});
	assign drain_emit = in_acc && (in_data.command == CMD_DRAIN) && in_done &&
	                    (out_cnt_q < total);
	assign emit       = pix_emit || drain_emit;
	assign out_next   = {1'b0, out_cnt_q} + 24'd1;
	assign last_px    = (out_next == {1'b0, total});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= 11'd640;
			fh_q <= 12'd480;
			ws_q <= 3'd3;
			fe_q <= 1'b1;
		end else if (cfg_acc) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:   fw_q <= cfg_data[10:0];
				REG_FRAME_HEIGHT:  fh_q <= cfg_data;
				REG_WINDOW_SIZE:   ws_q <= cfg_data[2:0];
				REG_FILTER_ENABLE: fe_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q   <= '0;
			out_cnt_q  <= '0;
			wr_addr_q  <= '0;
			out_addr_q <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
		end else if ((cfg_acc && cfg_known) || (emit && out_next >= {1'b0, total})) begin
			// config write to a known register or last output of the frame: start over
			in_cnt_q   <= '0;
			out_cnt_q  <= '0;
			wr_addr_q  <= '0;
			out_addr_q <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
		end else begin
			if (pix_ok) begin
				in_cnt_q  <= in_cnt_q + 23'd1;
				wr_addr_q <= addr_add(wr_addr_q, AW'(1));
			end
			if (emit) begin
				out_cnt_q  <= out_cnt_q + 23'd1;
				out_addr_q <= addr_add(out_addr_q, AW'(1));
				if ({1'b0, out_col_q} + 11'd1 >= w_eff) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + 12'd1;
				end else begin
					out_col_q <= out_col_q + 10'd1;
				end
			end
		end
	end

	// line store
	logic [23:0] mem [STORE_DEPTH];
	logic [23:0] rd_s1;

	always_ff @(posedge clk) begin
		if (pix_ok) mem[wr_addr_q] <= {in_data.red_in, in_data.green_in, in_data.blue_in};
	end

	// window walk
	logic [AW-1:0]      addr_q, row_addr_q;
	logic signed [12:0] rr_q, cc_q, cc0_q;
	logic [2:0]         dx_q, dy_q;
	logic               last_q;
	logic               inb;
	logic               rd_en_s1, inb_s1;
	logic               walk_end;

	assign inb = !rr_q[12] && (rr_q[11:0] < h_eff) && !cc_q[12] && (cc_q[11:0] < {1'b0, w_eff});
	assign walk_end = (dx_q == k_eff - 3'd1) && (dy_q == k_eff - 3'd1);

	always_ff @(posedge clk) begin
		rd_s1 <= mem[addr_q];
		if (emit) begin
			addr_q     <= addr_sub(out_addr_q, lag);
			row_addr_q <= addr_sub(out_addr_q, lag);
			rr_q       <= $signed({1'b0, out_row_q}) - $signed({11'b0, half});
			cc_q       <= $signed({3'b0, out_col_q}) - $signed({11'b0, half});
			cc0_q      <= $signed({3'b0, out_col_q}) - $signed({11'b0, half});
			dx_q       <= '0;
			dy_q       <= '0;
			last_q     <= last_px;
		end else if (state_q == ST_GATHER) begin
			if (dx_q == k_eff - 3'd1) begin
				dx_q       <= '0;
				dy_q       <= dy_q + 3'd1;
				rr_q       <= rr_q + 13'sd1;
				cc_q       <= cc0_q;
				row_addr_q <= addr_add(row_addr_q, AW'(w_eff));
				addr_q     <= addr_add(row_addr_q, AW'(w_eff));
			end else begin
				dx_q   <= dx_q + 3'd1;
				cc_q   <= cc_q + 13'sd1;
				addr_q <= addr_add(addr_q, AW'(1));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_en_s1 <= 1'b0;
			inb_s1   <= 1'b0;
		end else begin
			rd_en_s1 <= (state_q == ST_GATHER);
			inb_s1   <= inb;
		end
	end

	// sort chain
	sort_ctl_t   sctl;
	trio_t       sx;
	logic [23:0] median;

	assign sctl.clear  = emit;
	assign sctl.insert = rd_en_s1;
	// samples outside the frame go in as zero
	assign sx[2] = inb_s1 ? {1'b0, rd_s1[23:16]} : 9'd0;
	assign sx[1] = inb_s1 ? {1'b0, rd_s1[15:8]}  : 9'd0;
	assign sx[0] = inb_s1 ? {1'b0, rd_s1[7:0]}   : 9'd0;

	rmf_sorter u_sorter (
		.clk    (clk),
		.ctl    (sctl),
		.x      (sx),
		.rank   (rank),
		.median (median)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:   if (emit) state_q <= ST_GATHER;
				ST_GATHER: if (walk_end) state_q <= ST_WAIT;
				ST_WAIT:   state_q <= ST_CAPT;
				ST_CAPT:   state_q <= ST_OUT;
				ST_OUT:    if (!out_stall) state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	out_item_t out_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_CAPT) begin
			out_q.red_out    <= median[23:16];
			out_q.green_out  <= median[15:8];
			out_q.blue_out   <= median[7:0];
			out_q.frame_last <= last_q;
		end
	end

	assign out_valid = (state_q == ST_OUT);
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	// a waiting result must hold off new items
	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input accepted while result pending");

	// the sort chain is fed only during a window walk
	a_insert_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en_s1 |-> (state_q == ST_GATHER || state_q == ST_WAIT))
		else $error("sort insert outside window walk");

	// output position never reaches the frame size
	a_out_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_cnt_q < total)
		else $error("output counter past frame end");
`endif

endmodule
